@@ src/canny_nonmax_suppression_top_assert.svh @@
// Assertion macros for the non-maximum suppression block.
// Used by canny_nonmax_suppression_top; expects clk and rst_n in scope.
`ifndef CANNY_NONMAX_SUPPRESSION_TOP_ASSERT_SVH
`define CANNY_NONMAX_SUPPRESSION_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CNMS_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CNMS_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ src/cnms_pkg.sv @@
// Shared types and constants for the non-maximum suppression block.
// No dependencies; imported by canny_nonmax_suppression_top.
`default_nettype none

package cnms_pkg;

    // Field widths fixed by the stream format
    localparam int POS_X_W   = 6;
    localparam int POS_Y_W   = 6;
    localparam int POS_Z_W   = 4;
    localparam int IN_MAG_W  = 16;
    localparam int DIR_W     = 6;
    localparam int OUT_VAL_W = 16;
    localparam int SIZE_XY_W = 7;
    localparam int SIZE_Z_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    // Command codes carried in tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_D_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z       = 2'd3;

    // Configuration reset values
    localparam logic                 RST_THREE_D_MODE = 1'b0;
    localparam logic [SIZE_XY_W-1:0] RST_SIZE_X       = 7'd64;
    localparam logic [SIZE_XY_W-1:0] RST_SIZE_Y       = 7'd64;
    localparam logic [SIZE_Z_W-1:0]  RST_SIZE_Z       = 5'd16;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CENTER,
        ST_NEAR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ src/canny_nonmax_suppression_top.sv @@
// Non-maximum suppression over a voxel volume held in one single-port RAM.
// Depends on cnms_pkg and canny_nonmax_suppression_top_assert.svh.
//
// Usage:
//   s_axis carries one word per item: tuser is the command (write or query),
//   tdata packs the voxel position, gradient magnitude and direction.
//   m_axis returns one word per query: tdata is the kept magnitude, tuser the
//   status flag (coordinate outside the configured volume). Writes return none.
//   The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets mode and
//   volume size; it is always ready. The user must write it only while the
//   block is idle; the block does not enforce this. A write is accepted, then
//   written to the RAM in decode. A query is accepted and decoded, then reads
//   the centre, direct neighbour and opposed neighbour through the one RAM
//   port, one read a cycle, registered, and loads its result into the output
//   register. Border and outside queries skip the reads. Items go one at a time.
//   Stall: a result waits in the output register; the next item is accepted
//   meanwhile, and a further query holds in its last step until the register
//   frees up.
//   Reset: sequencer and output valid clear, configuration registers take their
//   reset values. RAM contents are undefined until written; no clearing pass.
`default_nettype none

module canny_nonmax_suppression_top
    import cnms_pkg::*;
#(
    parameter int MAX_X    = 64,
    parameter int MAX_Y    = 64,
    parameter int MAX_Z    = 16,
    parameter int MAG_BITS = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // Configuration write channel
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [CFG_IDX_W-1:0]         cfg_index,
    input  wire  [CFG_DAT_W-1:0]         cfg_data,
    // Input stream
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: pos_x[5:0], pos_y[11:6], pos_z[15:12], grad_mag[31:16],
    //        grad_dir[37:32], zero fill [39:38]
    input  wire  [39:0]                  s_axis_tdata,
    // tuser: cmd[0]
    input  wire                          s_axis_tuser,
    // Output stream
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // tdata: kept_value[15:0]
    output logic [OUT_VAL_W-1:0]         m_axis_tdata,
    // tuser: status[0]
    output logic                         m_axis_tuser
);

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = MAG_BITS + DIR_W;

    localparam logic [AW-1:0] STRIDE_X = AW'(1);
    localparam logic [AW-1:0] STRIDE_Y = AW'(MAX_X);
    localparam logic [AW-1:0] STRIDE_Z = AW'(MAX_X * MAX_Y);

    // Signed step along one axis as a modular address offset
    function automatic logic [AW-1:0] axis_term(input logic [1:0] bits,
                                                input logic [AW-1:0] stride);
        logic [AW-1:0] term;
        unique case (bits)
            2'b01:   term = stride;
            2'b10:   term = AW'(0) - stride;
            default: term = AW'(0);
        endcase
        return term;
    endfunction

    // Configuration registers
    logic                 three_d_reg;
    logic [SIZE_XY_W-1:0] size_x_reg;
    logic [SIZE_XY_W-1:0] size_y_reg;
    logic [SIZE_Z_W-1:0]  size_z_reg;
    logic                 cfg_accept;

    // Item registers
    logic                 cmd_reg;
    logic [POS_X_W-1:0]   x_reg;
    logic [POS_Y_W-1:0]   y_reg;
    logic [POS_Z_W-1:0]   z_reg;
    logic [MAG_BITS-1:0]  mag_reg;
    logic [DIR_W-1:0]     dir_reg;
    logic                 in_accept;

    // Sequencer
    state_t               state_reg;
    state_t               state_next;

    // Query working registers
    logic [AW-1:0]        c_addr_reg;
    logic [AW-1:0]        c_addr_next;
    logic [AW-1:0]        off_reg;
    logic [AW-1:0]        off_next;
    logic [MAG_BITS-1:0]  cmag_reg;
    logic                 gt_near_reg;
    logic                 early_reg;
    logic                 early_status_reg;

    // RAM and its port
    logic [EW-1:0]        mem [DEPTH];
    logic [EW-1:0]        mem_rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_addr;

    // Output register
    logic                 out_valid_reg;
    logic [OUT_VAL_W-1:0] out_value_reg;
    logic                 out_status_reg;
    logic                 out_load;
    logic [OUT_VAL_W-1:0] res_value;

    // Decode of the current item
    logic [SIZE_XY_W-1:0] sx;
    logic [SIZE_XY_W-1:0] sy;
    logic [SIZE_Z_W-1:0]  sz;
    logic [POS_Z_W-1:0]   z_eff;
    logic                 in_volume;
    logic                 interior;
    logic [DIR_W-1:0]     dir_c;
    logic [MAG_BITS-1:0]  rd_mag;

    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_d_reg <= RST_THREE_D_MODE;
            size_x_reg  <= RST_SIZE_X;
            size_y_reg  <= RST_SIZE_Y;
            size_z_reg  <= RST_SIZE_Z;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_THREE_D_MODE: three_d_reg <= cfg_data[0];
                CFG_SIZE_X:       size_x_reg  <= cfg_data;
                CFG_SIZE_Y:       size_y_reg  <= cfg_data;
                CFG_SIZE_Z:       size_z_reg  <= cfg_data[SIZE_Z_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= s_axis_tuser;
            x_reg   <= s_axis_tdata[5:0];
            y_reg   <= s_axis_tdata[11:6];
            z_reg   <= s_axis_tdata[15:12];
            mag_reg <= MAG_BITS'(s_axis_tdata[31:16]);
            dir_reg <= s_axis_tdata[37:32];
        end
    end

    // Effective volume size, clamped to the RAM geometry
    assign sx    = (32'(size_x_reg) > MAX_X) ? SIZE_XY_W'(MAX_X) : size_x_reg;
    assign sy    = (32'(size_y_reg) > MAX_Y) ? SIZE_XY_W'(MAX_Y) : size_y_reg;
    assign sz    = !three_d_reg ? SIZE_Z_W'(1) :
                   ((32'(size_z_reg) > MAX_Z) ? SIZE_Z_W'(MAX_Z) : size_z_reg);
    assign z_eff = three_d_reg ? z_reg : '0;

    assign in_volume = ({1'b0, x_reg} < sx) && ({1'b0, y_reg} < sy) &&
                       ({1'b0, z_eff} < sz);

    // Border voxels of any active axis are never kept
    assign interior = (x_reg != '0) && (({1'b0, x_reg} + 7'd1) != sx) &&
                      (y_reg != '0) && (({1'b0, y_reg} + 7'd1) != sy) &&
                      (!three_d_reg ||
                       ((z_eff != '0) && (({1'b0, z_eff} + 5'd1) != sz)));

    // Centre address and neighbour offset
    assign c_addr_next = AW'(x_reg) +
                         STRIDE_Y * (AW'(y_reg) + AW'(MAX_Y) * AW'(z_eff));
    assign dir_c       = mem_rdata_reg[EW-1:MAG_BITS] &
                         (three_d_reg ? 6'h3F : 6'h0F);
    assign off_next    = axis_term(dir_c[1:0], STRIDE_X) +
                         axis_term(dir_c[3:2], STRIDE_Y) +
                         axis_term(dir_c[5:4], STRIDE_Z);
    assign rd_mag      = mem_rdata_reg[MAG_BITS-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                priority if (cmd_reg == CMD_WRITE)
                    state_next = ST_IDLE;
                else if (!in_volume || !interior)
                    state_next = ST_DONE;
                else
                    state_next = ST_CENTER;
            end
            ST_CENTER: state_next = ST_NEAR;
            ST_NEAR:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // RAM port control and result load
    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = c_addr_reg;
        out_load = 1'b0;
        unique case (state_reg)
            ST_DECODE:
            begin
                mem_addr = c_addr_next;
                mem_we   = (cmd_reg == CMD_WRITE) && in_volume;
                mem_re   = (cmd_reg == CMD_QUERY) && in_volume && interior;
            end
            ST_CENTER:
            begin
                mem_addr = c_addr_reg + off_next;
                mem_re   = 1'b1;
            end
            ST_NEAR:
            begin
                mem_addr = c_addr_reg - off_reg;
                mem_re   = 1'b1;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default: ;
        endcase
    end

    // Single-port RAM, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= {dir_reg, mag_reg};
        if (mem_re)
            mem_rdata_reg <= mem[mem_addr];
    end

    // Sequencer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Query working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECODE)
        begin
            c_addr_reg       <= c_addr_next;
            early_reg        <= !in_volume || !interior;
            early_status_reg <= in_volume ? STATUS_OK : STATUS_OUTSIDE;
        end
        if (state_reg == ST_CENTER)
        begin
            cmag_reg <= rd_mag;
            off_reg  <= off_next;
        end
        if (state_reg == ST_NEAR)
            gt_near_reg <= cmag_reg > rd_mag;
    end

    // Kept only when strictly above both neighbours; a zero centre never is
    assign res_value = (!early_reg && gt_near_reg && (cmag_reg > rd_mag)) ?
                       OUT_VAL_W'(cmag_reg) : '0;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= early_status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    // Checks
    `include "canny_nonmax_suppression_top_assert.svh"

    `CNMS_ASSERT_SAME(a_one_port_access, mem_we, !mem_re, "RAM read and write in one cycle")
    `CNMS_ASSERT_SAME(a_write_cmd_only, mem_we, cmd_reg == CMD_WRITE, "RAM write from a query")
    `CNMS_ASSERT_NEXT(a_accept_decodes, in_accept, state_reg == ST_DECODE, "accept not decoded")
    `CNMS_ASSERT_NEXT(a_result_loaded, out_load, out_valid_reg, "result lost at load")
    `CNMS_ASSERT_SAME(a_neighbor_reads, state_reg == ST_CENTER || state_reg == ST_NEAR, mem_re,
                      "neighbour read missing")

endmodule

`default_nettype wire

@@ tb/tb_canny_nonmax_suppression_top.sv @@
// Self-checking testbench for canny_nonmax_suppression_top: voxel writes, suppression
// queries and configuration changes, checked against an in-bench predictor.
// Depends on cnms_pkg and the DUT sources only.
`timescale 1ns / 1ps

module tb_canny_nonmax_suppression_top;

    import cnms_pkg::*;

    // Volume bounds the DUT is built with
    localparam int DIM_X = 64;
    localparam int DIM_Y = 64;
    localparam int DIM_Z = 16;
    localparam int STORE_WORDS = DIM_X * DIM_Y * DIM_Z;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int END_CYCLES     = 20;
    localparam int PHASES         = 10;
    localparam int PHASE_WORDS    = 170;
    localparam int WIN_XY         = 6;
    localparam int WIN_Z          = 4;

    typedef struct packed {
        logic [OUT_VAL_W-1:0] kept;
        logic                 status;
    } result_word_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_TOGGLE
    } ready_mode_t;

    // DUT ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_VAL_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // Predictor state: volume contents and register copies
    bit [IN_MAG_W-1:0] mag_store [0:STORE_WORDS-1];
    bit [DIR_W-1:0]    dir_store [0:STORE_WORDS-1];
    bit                voxel_written [0:STORE_WORDS-1];
    bit                cfg_three_d = RST_THREE_D_MODE;
    int                cfg_size_x = RST_SIZE_X;
    int                cfg_size_y = RST_SIZE_Y;
    int                cfg_size_z = RST_SIZE_Z;

    result_word_t pending_results [$];
    result_word_t head_word;

    int error_count = 0;
    int words_sent = 0;
    int queries_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    // Receiver stall control
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    ready_mode_t stall_mode = READY_ALWAYS;

    canny_nonmax_suppression_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_size(input int s, input int lim);
        return (s > lim) ? lim : s;
    endfunction

    function automatic int vox_index(input int x, input int y, input int z);
        return (z * DIM_Y + y) * DIM_X + x;
    endfunction

    // +1 for the low bit of an axis pair, -1 for the high bit; both cancel
    function automatic int axis_offset(input logic [1:0] pair);
        return int'(pair[0]) - int'(pair[1]);
    endfunction

    function automatic int pick_mag();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(0, 3);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    // Mostly inside the working window, sometimes anywhere in the field range
    function automatic int pick_coord(input int lo, input int n, input int maxv);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, maxv);
        return lo + $urandom_range(0, n - 1);
    endfunction

    // Store a voxel the way a write word does: outside the volume it is dropped
    task automatic store_voxel(input int x, input int y, input int z,
                               input logic [IN_MAG_W-1:0] mag, input logic [DIR_W-1:0] dir);
        int zz;
        int idx;
        zz = cfg_three_d ? z : 0;
        if (x < eff_size(cfg_size_x, DIM_X) && y < eff_size(cfg_size_y, DIM_Y) &&
            zz < (cfg_three_d ? eff_size(cfg_size_z, DIM_Z) : 1))
        begin
            idx = vox_index(x, y, zz);
            mag_store[idx] = mag;
            dir_store[idx] = dir;
            voxel_written[idx] = 1'b1;
        end
    endtask

    // Suppressed value at a voxel; also flags a read of a voxel never written
    // and returns the position of the first such voxel
    task automatic predict_query(input int x, input int y, input int z,
                                 output logic [OUT_VAL_W-1:0] kept, output logic st,
                                 output bit unsafe, output int mx, output int my,
                                 output int mz);
        int sx, sy, sz, zz, dx, dy, dz, c, near_idx, far_idx;
        bit [IN_MAG_W-1:0] m;
        bit [DIR_W-1:0] d;
        sx = eff_size(cfg_size_x, DIM_X);
        sy = eff_size(cfg_size_y, DIM_Y);
        sz = cfg_three_d ? eff_size(cfg_size_z, DIM_Z) : 1;
        zz = cfg_three_d ? z : 0;
        kept = '0;
        st = STATUS_OK;
        unsafe = 1'b0;
        mx = x;
        my = y;
        mz = zz;
        if (!(x < sx && y < sy && zz < sz))
            st = STATUS_OUTSIDE;
        else if (x != 0 && x + 1 != sx && y != 0 && y + 1 != sy &&
                 (!cfg_three_d || (zz != 0 && zz + 1 != sz)))
        begin
            c = vox_index(x, y, zz);
            m = mag_store[c];
            d = dir_store[c];
            if (!cfg_three_d)
                d[5:4] = 2'b00;
            dx = axis_offset(d[1:0]);
            dy = axis_offset(d[3:2]);
            dz = axis_offset(d[5:4]);
            near_idx = vox_index(x + dx, y + dy, zz + dz);
            far_idx = vox_index(x - dx, y - dy, zz - dz);
            if (!voxel_written[c])
                unsafe = 1'b1;
            else if (!voxel_written[near_idx])
            begin
                unsafe = 1'b1;
                mx = x + dx;
                my = y + dy;
                mz = zz + dz;
            end
            else if (!voxel_written[far_idx])
            begin
                unsafe = 1'b1;
                mx = x - dx;
                my = y - dy;
                mz = zz - dz;
            end
            if (m != 0 && m > mag_store[near_idx] && m > mag_store[far_idx])
                kept = m;
        end
    endtask

    // Offer one word on the input stream, in bursts with random gaps,
    // and update the predictor once it is taken
    task automatic send_word(input logic cmd, input logic [POS_X_W-1:0] x,
                             input logic [POS_Y_W-1:0] y, input logic [POS_Z_W-1:0] z,
                             input logic [IN_MAG_W-1:0] mag, input logic [DIR_W-1:0] dir);
        int gap;
        logic [OUT_VAL_W-1:0] kept;
        logic st;
        bit unsafe;
        int mx, my, mz;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {2'b00, dir, mag, z, y, x};
        s_axis_tuser <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        if (cmd == CMD_QUERY)
        begin
            predict_query(x, y, z, kept, st, unsafe, mx, my, mz);
            pending_results.push_back('{kept: kept, status: st});
            queries_sent++;
        end
        else
            store_voxel(x, y, z, mag, dir);
    endtask

    // Stop offering, let every expected result arrive, then let writes settle
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DAT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
        case (idx)
            CFG_THREE_D_MODE: cfg_three_d = value[0];
            CFG_SIZE_X:       cfg_size_x = value & 'h7F;
            CFG_SIZE_Y:       cfg_size_y = value & 'h7F;
            CFG_SIZE_Z:       cfg_size_z = value & 'h1F;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic cfg_volume(input int mode, input int sx, input int sy, input int sz);
        cfg_write(CFG_THREE_D_MODE, mode);
        cfg_write(CFG_SIZE_X, sx);
        cfg_write(CFG_SIZE_Y, sy);
        cfg_write(CFG_SIZE_Z, sz);
    endtask

    // 2D at reset sizes: kept maximum, ties, cancelling bits, zero magnitude,
    // borders, ignored z and the full magnitude range
    task automatic test_directed_2d();
        send_word(CMD_WRITE, 4, 5, 0, 10, 6'b000000);
        send_word(CMD_WRITE, 6, 5, 0, 20, 6'b000000);
        send_word(CMD_WRITE, 5, 5, 0, 30, 6'b000001);
        send_word(CMD_QUERY, 5, 5, 0, 0, 0);
        // equal to one neighbour: suppressed
        send_word(CMD_WRITE, 5, 5, 0, 20, 6'b000010);
        send_word(CMD_QUERY, 5, 5, 0, 0, 0);
        // both x bits set: no move, compared with itself
        send_word(CMD_WRITE, 5, 5, 0, 16'hFFFF, 6'b000011);
        send_word(CMD_QUERY, 5, 5, 0, 0, 0);
        send_word(CMD_WRITE, 5, 5, 0, 0, 6'b000001);
        send_word(CMD_QUERY, 5, 5, 0, 0, 0);
        // y axis, largest magnitude; z bits must be ignored in 2D
        send_word(CMD_WRITE, 5, 4, 0, 1, 6'b000000);
        send_word(CMD_WRITE, 5, 6, 0, 0, 6'b000000);
        send_word(CMD_WRITE, 5, 5, 0, 16'hFFFF, 6'b110100);
        send_word(CMD_QUERY, 5, 5, 0, 0, 0);
        send_word(CMD_QUERY, 0, 5, 0, 0, 0);
        send_word(CMD_QUERY, 63, 63, 0, 0, 0);
        send_word(CMD_QUERY, 5, 5, 15, 16'hFFFF, 6'b111111);
        // diagonal neighbours, then a write with z set lands on layer 0
        send_word(CMD_WRITE, 6, 4, 0, 499, 6'b000000);
        send_word(CMD_WRITE, 4, 6, 0, 3, 6'b000000);
        send_word(CMD_WRITE, 5, 5, 15, 500, 6'b101001);
        send_word(CMD_QUERY, 5, 5, 0, 0, 0);
        send_word(CMD_WRITE, 5, 5, 9, 500, 6'b000001);
        send_word(CMD_QUERY, 5, 5, 0, 0, 0);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while queries keep coming
    task automatic test_output_backpressure();
        hold_requests++;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 2 == 0)
                send_word(CMD_QUERY, 5, 5, $urandom_range(0, 15), 0, 0);
            else
                send_word(CMD_QUERY, 0, $urandom_range(0, 63), 0, 0, 0);
        end
        wait_drained();
    endtask

    // 3D: z moves, borders on z, sizes above the limit, zero and one
    task automatic test_volume_3d();
        cfg_volume(1, 3, 3, 3);
        send_word(CMD_WRITE, 1, 1, 0, 5, 6'b000000);
        send_word(CMD_WRITE, 1, 1, 2, 6, 6'b000000);
        send_word(CMD_WRITE, 1, 1, 1, 9, 6'b010000);
        send_word(CMD_QUERY, 1, 1, 1, 0, 0);
        send_word(CMD_WRITE, 1, 1, 1, 6, 6'b100000);
        send_word(CMD_QUERY, 1, 1, 1, 0, 0);
        send_word(CMD_WRITE, 1, 1, 1, 6, 6'b110000);
        send_word(CMD_QUERY, 1, 1, 1, 0, 0);
        send_word(CMD_QUERY, 1, 1, 0, 0, 0);
        send_word(CMD_QUERY, 1, 1, 3, 0, 0);
        send_word(CMD_QUERY, 3, 1, 1, 0, 0);
        wait_drained();
        cfg_write(CFG_SIZE_Z, 31);
        send_word(CMD_QUERY, 1, 1, 15, 0, 0);
        send_word(CMD_QUERY, 1, 1, 1, 0, 0);
        wait_drained();
        cfg_write(CFG_SIZE_Z, 1);
        send_word(CMD_QUERY, 1, 1, 0, 0, 0);
        send_word(CMD_QUERY, 1, 1, 1, 0, 0);
        wait_drained();
        cfg_write(CFG_SIZE_Z, 0);
        send_word(CMD_QUERY, 1, 1, 0, 0, 0);
        wait_drained();
    endtask

    // 2D size extremes: empty volume, one- and two-wide axes, sizes above the limit
    task automatic test_size_limits();
        cfg_volume(0, 0, 64, 16);
        send_word(CMD_WRITE, 0, 0, 0, 77, 6'b000001);
        send_word(CMD_QUERY, 0, 0, 0, 0, 0);
        wait_drained();
        cfg_write(CFG_SIZE_X, 127);
        cfg_write(CFG_SIZE_Y, 1);
        send_word(CMD_QUERY, 63, 0, 0, 0, 0);
        send_word(CMD_QUERY, 0, 1, 0, 0, 0);
        wait_drained();
        cfg_write(CFG_SIZE_X, 2);
        cfg_write(CFG_SIZE_Y, 127);
        send_word(CMD_QUERY, 1, 63, 0, 0, 0);
        send_word(CMD_QUERY, 2, 10, 0, 0, 0);
        wait_drained();
    endtask

    task automatic pick_window(input int s, input int w, output int lo, output int n);
        n = (s < w) ? ((s == 0) ? 1 : s) : w;
        lo = (s > n) ? $urandom_range(0, s - n) : 0;
    endtask

    // Random phases: each sets a volume, then mixes writes and queries in a
    // small window; a query that would read an unwritten voxel turns into a
    // write of that voxel
    task automatic test_random_traffic();
        int mode, sx, sy, sz, x0, xn, y0, yn, z0, zn, x, y, z;
        logic [OUT_VAL_W-1:0] kept;
        logic st;
        bit unsafe;
        int mx, my, mz;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 5)
                0: begin mode = 0; sx = $urandom_range(3, 8); sy = $urandom_range(3, 8);
                         sz = $urandom_range(0, 31); end
                1: begin mode = 1; sx = $urandom_range(3, 6); sy = $urandom_range(3, 6);
                         sz = $urandom_range(3, 5); end
                2: begin mode = 1; sx = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
                         sy = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
                         sz = $urandom_range(0, 1) ? 16 : $urandom_range(17, 31); end
                3: begin mode = 0; sx = $urandom_range(0, 1) ? 64 : 127;
                         sy = $urandom_range(0, 1) ? 64 : 127; sz = $urandom_range(0, 31); end
                default: begin mode = $urandom_range(0, 1); sx = $urandom_range(0, 3);
                         sy = $urandom_range(0, 3); sz = $urandom_range(0, 3); end
            endcase
            cfg_volume(mode, sx, sy, sz);
            pick_window(eff_size(sx, DIM_X), WIN_XY, x0, xn);
            pick_window(eff_size(sy, DIM_Y), WIN_XY, y0, yn);
            pick_window(eff_size(sz, DIM_Z), WIN_Z, z0, zn);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                x = pick_coord(x0, xn, 63);
                y = pick_coord(y0, yn, 63);
                z = mode ? pick_coord(z0, zn, 15) : $urandom_range(0, 15);
                if ($urandom_range(0, 99) < 40)
                    send_word(CMD_WRITE, x, y, z, pick_mag(), $urandom_range(0, 63));
                else
                begin
                    predict_query(x, y, z, kept, st, unsafe, mx, my, mz);
                    if (!unsafe)
                        send_word(CMD_QUERY, x, y, z, pick_mag(), $urandom_range(0, 63));
                    else
                        send_word(CMD_WRITE, mx, my, mode ? mz : $urandom_range(0, 15),
                                  pick_mag(), $urandom_range(0, 63));
                end
            end
            wait_drained();
        end
    endtask

    // Receiver: long hold on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = ready_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(8, 60);
            end
            stall_left--;
            case (stall_mode)
                READY_ALWAYS: m_axis_tready <= 1'b1;
                READY_COIN:   m_axis_tready <= $urandom_range(0, 1);
                READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:      m_axis_tready <= stall_left[0];
            endcase
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: kept_value %0d status %0d",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                head_word = pending_results.pop_front();
                if (m_axis_tdata !== head_word.kept)
                begin
                    $error("kept_value mismatch: expected %0d, actual %0d",
                           head_word.kept, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== head_word.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           head_word.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a handshake", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_2d();
        test_output_backpressure();
        test_volume_3d();
        test_size_limits();
        test_random_traffic();
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        $display("Sent %0d words (%0d queries), checked %0d results, %0d register writes",
                 words_sent, queries_sent, results_checked, cfg_writes);
        $display("Covered 2D and 3D volumes, size extremes, borders and output stalls");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
